// File: rtl/core/memory_reservation_admission_macros.svh
// assertion macros shared by the reservation admission modules
// expects clk and arst_n in the scope of every use
`ifndef MEMORY_RESERVATION_ADMISSION_MACROS_SVH
`define MEMORY_RESERVATION_ADMISSION_MACROS_SVH

// same-cycle implication, off while in reset
`define MRA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while in reset
`define MRA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/mra_pkg.sv
// types and codes shared by the reservation admission modules
// no dependencies
`default_nettype none

package mra_pkg;

	localparam int ACT_W    = 3;
	localparam int STATUS_W = 2;

	// request codes
	typedef enum logic [ACT_W-1:0] {
		ACT_APPLY   = 3'd0,
		ACT_RELEASE = 3'd1,
		ACT_REFRESH = 3'd2,
		ACT_STOP    = 3'd3,
		ACT_CLEAR   = 3'd4
	} mra_action_t;

	// result codes
	typedef enum logic [STATUS_W-1:0] {
		STS_OK      = 2'd0,
		STS_STOPPED = 2'd1,
		STS_RETRY   = 2'd2,
		STS_FULL    = 2'd3
	} mra_status_t;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_DRAIN,
		S_COMMIT
	} mra_state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic sum_acc;
		logic sum_take;
		logic scan_run;
		logic commit;
	} mra_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [ACT_W-1:0] act;
		logic             last;
		logic             stopped;
		logic             hit;
		logic             last_issue;
	} mra_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/mra_channels.sv
// request and result channel interfaces, valid/ready handshake
// depends on mra_pkg
`default_nettype none

interface mra_in_if import mra_pkg::*; #(
	parameter int KEY_BITS = 32,
	parameter int MEM_BITS = 48
) ();
	logic                valid;
	logic                ready;
	logic [ACT_W-1:0]    action;
	logic [KEY_BITS-1:0] task_key;
	logic [MEM_BITS-1:0] memory_size;
	logic                last_element;
	logic [MEM_BITS-1:0] new_limit;

	modport source (output valid, action, task_key, memory_size, last_element, new_limit,
		input ready);
	modport sink (input valid, action, task_key, memory_size, last_element, new_limit,
		output ready);
endinterface

interface mra_out_if import mra_pkg::*; #(
	parameter int MEM_BITS = 48
) ();
	logic                       valid;
	logic                       ready;
	logic [STATUS_W-1:0]        status;
	logic signed [MEM_BITS:0]   remaining;
	logic [MEM_BITS-1:0]        total;

	modport source (output valid, status, remaining, total, input ready);
	modport sink (input valid, status, remaining, total, output ready);
endinterface

`default_nettype wire

// File: rtl/core/mra_ctrl.sv
// controller state machine for the reservation admission block
// depends on mra_pkg and memory_reservation_admission_macros.svh
`default_nettype none
`include "memory_reservation_admission_macros.svh"

module mra_ctrl import mra_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  mra_sts_t sts,
	output mra_cmd_t cmd
);

	mra_state_t state_q, state_d;
	logic       out_vld_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.act)
					ACT_APPLY: begin
						if (!sts.last) begin
							cmd.sum_acc = 1'b1;
							state_d     = S_IDLE;
						end else begin
							cmd.sum_take = 1'b1;
							state_d      = sts.stopped ? S_COMMIT : S_SCAN;
						end
					end
					ACT_RELEASE: state_d = S_SCAN;
					ACT_REFRESH, ACT_STOP, ACT_CLEAR: state_d = S_COMMIT;
					default: state_d = S_IDLE;
				endcase
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (sts.hit) begin
					state_d = S_COMMIT;
				end else if (sts.last_issue) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: state_d = S_COMMIT;
			S_COMMIT: begin
				// result register must be empty or emptying
				if (!out_vld_q || out_ready) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.commit) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign out_valid = out_vld_q;

	`MRA_ASSERT_IMP(a_no_overwrite, cmd.commit, !out_vld_q || out_ready, "pending result overwritten")
	`MRA_ASSERT_IMP(a_scan_action, state_q == S_SCAN, sts.act == ACT_APPLY || sts.act == ACT_RELEASE, "table scan for an action that needs none")
	`MRA_ASSERT_NXT(a_commit_free, state_q == S_COMMIT && !out_vld_q, state_q == S_IDLE && out_vld_q, "commit stalled with an empty result register")

endmodule

`default_nettype wire

// File: rtl/core/mra_dp.sv
// datapath: request registers, key table, scan pipeline, accounting, result register
// depends on mra_pkg and memory_reservation_admission_macros.svh
`default_nettype none
`include "memory_reservation_admission_macros.svh"

module mra_dp import mra_pkg::*; #(
	parameter int TABLE_ENTRIES = 64,
	parameter int KEY_BITS      = 32,
	parameter int MEM_BITS      = 48
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mra_cmd_t                   cmd,
	output mra_sts_t                   sts,
	input  logic [ACT_W-1:0]           in_action,
	input  logic [KEY_BITS-1:0]        in_key,
	input  logic [MEM_BITS-1:0]        in_size,
	input  logic                       in_last,
	input  logic [MEM_BITS-1:0]        in_limit,
	output logic [STATUS_W-1:0]        res_status,
	output logic signed [MEM_BITS:0]   res_remaining,
	output logic [MEM_BITS-1:0]        res_total
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
	localparam int REM_W = MEM_BITS + 1;
	localparam int EXT_W = MEM_BITS + 2;

	// saturate a widened remaining value into its signed range
	function automatic logic signed [REM_W-1:0] clamp_rem(input logic signed [EXT_W-1:0] v);
		logic signed [REM_W-1:0] r;
		if (v[EXT_W-1] != v[EXT_W-2]) begin
			r = v[EXT_W-1] ? {1'b1, {MEM_BITS{1'b0}}} : {1'b0, {MEM_BITS{1'b1}}};
		end else begin
			r = v[REM_W-1:0];
		end
		return r;
	endfunction

	// captured request
	logic [ACT_W-1:0]    act_q;
	logic [KEY_BITS-1:0] key_q;
	logic [MEM_BITS-1:0] size_q;
	logic                last_q;
	logic [MEM_BITS-1:0] limit_q;

	// accounting state
	logic [MEM_BITS-1:0]     request_sum_q;
	logic [MEM_BITS-1:0]     amt_q;
	logic [MEM_BITS-1:0]     total_q;
	logic signed [REM_W-1:0] rem_q;
	logic                    stopped_q;
	logic [TABLE_ENTRIES-1:0] valid_q;

	// key table
	logic [KEY_BITS-1:0] key_mem [TABLE_ENTRIES];
	logic [MEM_BITS-1:0] amt_mem [TABLE_ENTRIES];

	// scan pipeline
	logic [IDX_W-1:0]    idx_q;
	logic                free_found_q;
	logic [IDX_W-1:0]    free_idx_q;
	logic                live_s1;
	logic                vld_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [KEY_BITS-1:0] key_rd_s1;
	logic [MEM_BITS-1:0] amt_rd_s1;
	logic                hit_q;
	logic [IDX_W-1:0]    slot_q;
	logic [MEM_BITS-1:0] hit_amt_q;

	// commit results
	logic [MEM_BITS:0]       sum_ext;
	logic [MEM_BITS-1:0]     sum_sat;
	logic signed [EXT_W-1:0] rem_ext;
	logic signed [EXT_W-1:0] amt_ext;
	logic [STATUS_W-1:0]     sts_n;
	logic signed [REM_W-1:0] rem_n;
	logic [MEM_BITS-1:0]     total_n;
	logic                    stop_n;
	logic                    store;
	logic                    drop;
	logic                    clear_all;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q   <= in_action;
			key_q   <= in_key;
			size_q  <= in_size;
			last_q  <= in_last;
			limit_q <= in_limit;
		end
	end

	// saturating element sum
	assign sum_ext = {1'b0, request_sum_q} + {1'b0, size_q};
	assign sum_sat = sum_ext[MEM_BITS] ? {MEM_BITS{1'b1}} : sum_ext[MEM_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			request_sum_q <= '0;
		end else if (cmd.sum_acc) begin
			request_sum_q <= sum_sat;
		end else if (cmd.sum_take) begin
			request_sum_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum_take) begin
			amt_q <= sum_sat;
		end
	end

	// scan control: index, first free entry, match flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			free_found_q <= 1'b0;
			hit_q        <= 1'b0;
			live_s1      <= 1'b0;
		end else begin
			live_s1 <= cmd.scan_run;
			if (cmd.capture) begin
				idx_q        <= '0;
				free_found_q <= 1'b0;
				hit_q        <= 1'b0;
			end else begin
				if (cmd.scan_run) begin
					if (idx_q != LAST_IDX) begin
						idx_q <= idx_q + 1'b1;
					end
					if (!valid_q[idx_q] && !free_found_q) begin
						free_found_q <= 1'b1;
					end
				end
				if (live_s1 && vld_s1 && key_rd_s1 == key_q && !hit_q) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	// scan payload
	always_ff @(posedge clk) begin
		if (cmd.scan_run && !valid_q[idx_q] && !free_found_q) begin
			free_idx_q <= idx_q;
		end
		if (live_s1 && vld_s1 && key_rd_s1 == key_q && !hit_q) begin
			slot_q    <= idx_s1;
			hit_amt_q <= amt_rd_s1;
		end
	end

	// table memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.commit && store) begin
			key_mem[free_idx_q] <= key_q;
			amt_mem[free_idx_q] <= amt_q;
		end
		if (cmd.scan_run) begin
			key_rd_s1 <= key_mem[idx_q];
			amt_rd_s1 <= amt_mem[idx_q];
			vld_s1    <= valid_q[idx_q];
			idx_s1    <= idx_q;
		end
	end

	// decision and new accounting values
	assign rem_ext = {rem_q[REM_W-1], rem_q};
	assign amt_ext = {2'b00, amt_q};

	always_comb begin
		sts_n     = STS_OK;
		rem_n     = rem_q;
		total_n   = total_q;
		stop_n    = stopped_q;
		store     = 1'b0;
		drop      = 1'b0;
		clear_all = 1'b0;
		case (act_q)
			ACT_APPLY: begin
				if (stopped_q) begin
					sts_n = STS_STOPPED;
				end else if (hit_q) begin
					sts_n = STS_OK;
				end else if (amt_ext > rem_ext) begin
					sts_n = STS_RETRY;
				end else if (!free_found_q) begin
					sts_n = STS_FULL;
				end else begin
					store = 1'b1;
					rem_n = clamp_rem(rem_ext - amt_ext);
				end
			end
			ACT_RELEASE: begin
				if (hit_q) begin
					drop  = 1'b1;
					rem_n = clamp_rem(rem_ext + $signed({2'b00, hit_amt_q}));
				end
			end
			ACT_REFRESH: begin
				rem_n   = clamp_rem(rem_ext + $signed({2'b00, limit_q})
					- $signed({2'b00, total_q}));
				total_n = limit_q;
			end
			ACT_STOP: stop_n = 1'b1;
			ACT_CLEAR: begin
				clear_all = 1'b1;
				rem_n     = {1'b0, total_q};
			end
			default: ;
		endcase
	end

	// accounting registers and entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q     <= '0;
			total_q   <= '0;
			stopped_q <= 1'b0;
			valid_q   <= '0;
		end else if (cmd.commit) begin
			rem_q     <= rem_n;
			total_q   <= total_n;
			stopped_q <= stop_n;
			if (clear_all) begin
				valid_q <= '0;
			end else if (store) begin
				valid_q[free_idx_q] <= 1'b1;
			end else if (drop) begin
				valid_q[slot_q] <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_status    <= sts_n;
			res_remaining <= rem_n;
			res_total     <= total_n;
		end
	end

	// status to controller
	always_comb begin
		sts.act        = act_q;
		sts.last       = last_q;
		sts.stopped    = stopped_q;
		sts.hit        = hit_q;
		sts.last_issue = (idx_q == LAST_IDX);
	end

	`MRA_ASSERT_IMP(a_free_slot, cmd.commit && store, !valid_q[free_idx_q], "new key stored over a live entry")
	`MRA_ASSERT_IMP(a_hit_live, cmd.commit && hit_q, valid_q[slot_q], "matched entry is not live")
	`MRA_ASSERT_IMP(a_store_nonneg, cmd.commit && store, !rem_n[MEM_BITS], "admitted request drove remaining negative")

endmodule

`default_nettype wire

// File: rtl/core/memory_reservation_admission.sv
// top level of the keyed memory reservation admission controller
// depends on mra_pkg, mra_channels, mra_ctrl, mra_dp
//
//   channel  role    payload
//   req      sink    action, task_key, memory_size, last_element, new_limit
//   rsp      source  status, remaining, total
//
// one item at a time; req.ready is high only while the controller is idle
// refresh, stop and release-all go from decode straight to commit; a non-last apply element only adds to the sum
// apply (last element) and release run the key table scan: one entry read per cycle
// through the single table read port
// a match ends the scan early; a stopped apply skips it
// a held result does not block the next item, only its commit cycle waits for rsp.ready
// reset clears valid bits, totals and flags at once; no clearing pass is needed
`default_nettype none

module memory_reservation_admission import mra_pkg::*; #(
	parameter int TABLE_ENTRIES = 64,
	parameter int KEY_BITS      = 32,
	parameter int MEM_BITS      = 48
) (
	input  logic      clk,
	input  logic      arst_n,
	mra_in_if.sink    req,
	mra_out_if.source rsp
);

	mra_cmd_t cmd;
	mra_sts_t sts;

	// sequencing
	mra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// table, accounting and result register
	mra_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.KEY_BITS      (KEY_BITS),
		.MEM_BITS      (MEM_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_action     (req.action),
		.in_key        (req.task_key),
		.in_size       (req.memory_size),
		.in_last       (req.last_element),
		.in_limit      (req.new_limit),
		.res_status    (rsp.status),
		.res_remaining (rsp.remaining),
		.res_total     (rsp.total)
	);

endmodule

`default_nettype wire
